### sv/assert_macros.svh
// Assertion macros used by the heap queue top module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### sv/bmhq_pkg.sv
// Types and codes shared by the binary min-heap queue.
package bmhq_pkg;

  localparam int unsigned KEY_BITS   = 16;
  localparam int unsigned ID_BITS    = 16;
  localparam int unsigned COUNT_BITS = 9;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_POP    = 2'd1,
    MODE_UPDATE = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_MISSING = 2'd3
  } status_e;

  typedef struct packed {
    mode_e               mode;
    logic [KEY_BITS-1:0] key;
    logic [ID_BITS-1:0]  node_id;
  } req_t;

  typedef struct packed {
    status_e               status;
    logic [KEY_BITS-1:0]   out_key;
    logic [ID_BITS-1:0]    out_id;
    logic [COUNT_BITS-1:0] count;
  } res_t;

  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic [ID_BITS-1:0]  id;
  } entry_t;

endpackage

### sv/binary_min_heap_queue_top.sv
// Binary min-heap priority queue with a sequenced single-port sift engine.
// Insert sifts up level by level, pop sifts the last entry down from the root, update
// searches entry by entry, then sifts up and down; clear, full and empty end in idle.
// Every step waits on the one registered memory read port, one read per cycle.
// Reset empties the heap at once; the slot memory itself is not cleared.
// One command at a time: busy stays high until its result shows for one cycle on done_o.
`include "assert_macros.svh"

module binary_min_heap_queue_top #(
  parameter int unsigned CAPACITY = 256
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  bmhq_pkg::req_t  req_i,
  output logic            done_o,
  output bmhq_pkg::res_t  res_o
);

  localparam int unsigned ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
  localparam int unsigned IW     = ADDR_W + 2;

  typedef enum logic [3:0] {
    S_IDLE, S_SRCH, S_SRCH_CHK, S_UP, S_UP_CHK, S_RELOAD, S_RELOAD_CHK,
    S_POP_ROOT, S_POP_LAST, S_DN, S_DN_L, S_DN_R
  } state_e;

  state_e                  state_q;
  logic [CNT_W-1:0]        cnt_q;
  logic [CNT_W-1:0]        idx_q;
  logic [ADDR_W-1:0]       pos_q;
  logic [ADDR_W-1:0]       upd_q;
  logic                    is_upd_q;
  bmhq_pkg::entry_t        item_q;
  bmhq_pkg::entry_t        left_q;
  bmhq_pkg::entry_t        rd_q;
  logic                    done_q;
  bmhq_pkg::res_t          res_q;

  bmhq_pkg::entry_t        mem_q [CAPACITY];
  logic [ADDR_W-1:0]       raddr;
  logic                    we;
  logic [ADDR_W-1:0]       waddr;
  bmhq_pkg::entry_t        wdata;

  logic [ADDR_W-1:0]       parent;
  logic [IW-1:0]           lc_w;
  logic [IW-1:0]           rc_w;
  logic [IW-1:0]           cnt_w;
  logic                    has_rc;
  logic                    pick_r;
  bmhq_pkg::entry_t        pick;
  logic [ADDR_W-1:0]       pick_idx;

  assign parent   = (pos_q - ADDR_W'(1)) >> 1;
  assign lc_w     = IW'({pos_q, 1'b1});
  assign rc_w     = lc_w + IW'(1);
  assign cnt_w    = IW'(cnt_q);
  assign has_rc   = rc_w < cnt_w;
  assign pick_r   = has_rc && (rd_q.key < left_q.key);
  assign pick     = pick_r ? rd_q : left_q;
  assign pick_idx = pick_r ? rc_w[ADDR_W-1:0] : lc_w[ADDR_W-1:0];

  always_comb begin
    raddr = '0;
    we    = 1'b0;
    waddr = pos_q;
    wdata = item_q;
    unique case (state_q)
      S_SRCH:     raddr = idx_q[ADDR_W-1:0];
      S_UP: begin
        raddr = parent;
        we    = (pos_q == '0);
      end
      S_UP_CHK: begin
        we = 1'b1;
        if (rd_q.key > item_q.key) begin
          wdata = rd_q;
        end
      end
      S_RELOAD:   raddr = upd_q;
      S_POP_ROOT: raddr = '0;
      S_POP_LAST: raddr = cnt_q[ADDR_W-1:0];
      S_DN: begin
        raddr = lc_w[ADDR_W-1:0];
        we    = (lc_w >= cnt_w);
      end
      S_DN_L:     raddr = rc_w[ADDR_W-1:0];
      S_DN_R: begin
        we = 1'b1;
        if (pick.key < item_q.key) begin
          wdata = pick;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rd_q <= mem_q[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      done_q   <= 1'b0;
      is_upd_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (start) begin
            res_q.out_key <= '0;
            res_q.out_id  <= '0;
            res_q.status  <= bmhq_pkg::ST_OK;
            item_q.key    <= req_i.key;
            item_q.id     <= req_i.node_id;
            unique case (req_i.mode)
              bmhq_pkg::MODE_INSERT: begin
                if (cnt_q >= CNT_W'(CAPACITY)) begin
                  res_q.status <= bmhq_pkg::ST_FULL;
                  res_q.count  <= bmhq_pkg::COUNT_BITS'(cnt_q);
                  done_q       <= 1'b1;
                end else begin
                  pos_q    <= cnt_q[ADDR_W-1:0];
                  cnt_q    <= cnt_q + CNT_W'(1);
                  is_upd_q <= 1'b0;
                  state_q  <= S_UP;
                end
              end
              bmhq_pkg::MODE_POP: begin
                if (cnt_q == '0) begin
                  res_q.status <= bmhq_pkg::ST_EMPTY;
                  res_q.count  <= '0;
                  done_q       <= 1'b1;
                end else begin
                  state_q <= S_POP_ROOT;
                end
              end
              bmhq_pkg::MODE_UPDATE: begin
                idx_q    <= '0;
                is_upd_q <= 1'b1;
                state_q  <= S_SRCH;
              end
              bmhq_pkg::MODE_CLEAR: begin
                cnt_q       <= '0;
                res_q.count <= '0;
                done_q      <= 1'b1;
              end
              default: ;
            endcase
          end
        end
        S_SRCH: begin
          if (idx_q >= cnt_q) begin
            res_q.status <= bmhq_pkg::ST_MISSING;
            res_q.count  <= bmhq_pkg::COUNT_BITS'(cnt_q);
            done_q       <= 1'b1;
            state_q      <= S_IDLE;
          end else begin
            state_q <= S_SRCH_CHK;
          end
        end
        S_SRCH_CHK: begin
          if (rd_q.id == item_q.id) begin
            pos_q   <= idx_q[ADDR_W-1:0];
            upd_q   <= idx_q[ADDR_W-1:0];
            state_q <= S_UP;
          end else begin
            idx_q   <= idx_q + CNT_W'(1);
            state_q <= S_SRCH;
          end
        end
        S_UP: begin
          if (pos_q == '0) begin
            state_q <= is_upd_q ? S_RELOAD : S_IDLE;
            if (!is_upd_q) begin
              res_q.count <= bmhq_pkg::COUNT_BITS'(cnt_q);
              done_q      <= 1'b1;
            end
          end else begin
            state_q <= S_UP_CHK;
          end
        end
        S_UP_CHK: begin
          if (rd_q.key > item_q.key) begin
            pos_q   <= parent;
            state_q <= S_UP;
          end else begin
            state_q <= is_upd_q ? S_RELOAD : S_IDLE;
            if (!is_upd_q) begin
              res_q.count <= bmhq_pkg::COUNT_BITS'(cnt_q);
              done_q      <= 1'b1;
            end
          end
        end
        S_RELOAD: begin
          state_q <= S_RELOAD_CHK;
        end
        S_RELOAD_CHK: begin
          item_q  <= rd_q;
          pos_q   <= upd_q;
          state_q <= S_DN;
        end
        S_POP_ROOT: begin
          cnt_q   <= cnt_q - CNT_W'(1);
          state_q <= S_POP_LAST;
        end
        S_POP_LAST: begin
          res_q.out_key <= rd_q.key;
          res_q.out_id  <= rd_q.id;
          upd_q         <= '0;
          state_q       <= S_RELOAD_CHK;
        end
        S_DN: begin
          if (lc_w >= cnt_w) begin
            res_q.count <= bmhq_pkg::COUNT_BITS'(cnt_q);
            done_q      <= 1'b1;
            state_q     <= S_IDLE;
          end else begin
            state_q <= S_DN_L;
          end
        end
        S_DN_L: begin
          left_q  <= rd_q;
          state_q <= S_DN_R;
        end
        S_DN_R: begin
          if (pick.key < item_q.key) begin
            pos_q   <= pick_idx;
            state_q <= S_DN;
          end else begin
            res_q.count <= bmhq_pkg::COUNT_BITS'(cnt_q);
            done_q      <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

  `ASSERT_SAME(a_done_idle, done_o, !busy)
  `ASSERT_SAME(a_cnt_bound, 1'b1, cnt_q <= CNT_W'(CAPACITY))
  `ASSERT_SAME(a_full_cnt, done_o && res_o.status == bmhq_pkg::ST_FULL,
               res_o.count == bmhq_pkg::COUNT_BITS'(CAPACITY))
  `ASSERT_SAME(a_empty_cnt, done_o && res_o.status == bmhq_pkg::ST_EMPTY, res_o.count == '0)

endmodule

### test/tb_binary_min_heap_queue_top.sv
// Self-checking testbench for the binary min-heap queue against a behavioural heap.
module tb_binary_min_heap_queue_top;

  localparam int unsigned SLOTS = 256;
  localparam int unsigned WATCHDOG_LIMIT = 20000;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  bmhq_pkg::req_t req_i;
  logic done_o;
  bmhq_pkg::res_t res_o;

  binary_min_heap_queue_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .done_o (done_o),
    .res_o  (res_o)
  );

  bmhq_pkg::req_t pending_cmds[$];
  bmhq_pkg::res_t expected_res[$];
  logic [bmhq_pkg::KEY_BITS-1:0] heap_keys[SLOTS];
  logic [bmhq_pkg::ID_BITS-1:0] heap_ids[SLOTS];
  int unsigned heap_size;
  int unsigned sender_idle_pct;
  int unsigned error_count;
  int unsigned cmds_sent;
  int unsigned results_seen;
  int unsigned idle_cycles;
  int unsigned mode_hits[4];
  int unsigned status_hits[4];
  bit taken;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void add_cmd(bmhq_pkg::req_t c);
    pending_cmds.insert(pending_cmds.size(), c);
  endfunction

  function automatic void swap_entries(int unsigned a, int unsigned b);
    logic [bmhq_pkg::KEY_BITS-1:0] k;
    logic [bmhq_pkg::ID_BITS-1:0] d;
    k = heap_keys[a];
    d = heap_ids[a];
    heap_keys[a] = heap_keys[b];
    heap_ids[a] = heap_ids[b];
    heap_keys[b] = k;
    heap_ids[b] = d;
  endfunction

  function automatic void bubble_up(int unsigned pos);
    int unsigned p;
    p = pos;
    while (p > 0 && p < heap_size && heap_keys[(p - 1) / 2] > heap_keys[p]) begin
      swap_entries((p - 1) / 2, p);
      p = (p - 1) / 2;
    end
  endfunction

  function automatic void bubble_down(int unsigned pos);
    int unsigned p;
    int unsigned pick;
    p = pos;
    while (2 * p + 1 < heap_size) begin
      pick = 2 * p + 1;
      if (pick + 1 < heap_size && heap_keys[pick + 1] < heap_keys[pick]) pick = pick + 1;
      if (!(heap_keys[pick] < heap_keys[p])) break;
      swap_entries(pick, p);
      p = pick;
    end
  endfunction

  function automatic bmhq_pkg::res_t apply_cmd(bmhq_pkg::req_t cmd);
    bmhq_pkg::res_t r;
    r = '0;
    r.status = bmhq_pkg::ST_OK;
    case (cmd.mode)
      bmhq_pkg::MODE_INSERT: begin
        if (heap_size >= SLOTS) begin
          r.status = bmhq_pkg::ST_FULL;
        end else begin
          heap_keys[heap_size] = cmd.key;
          heap_ids[heap_size] = cmd.node_id;
          heap_size++;
          bubble_up(heap_size - 1);
        end
      end
      bmhq_pkg::MODE_POP: begin
        if (heap_size == 0) begin
          r.status = bmhq_pkg::ST_EMPTY;
        end else begin
          r.out_key = heap_keys[0];
          r.out_id = heap_ids[0];
          heap_size--;
          heap_keys[0] = heap_keys[heap_size];
          heap_ids[0] = heap_ids[heap_size];
          bubble_down(0);
        end
      end
      bmhq_pkg::MODE_UPDATE: begin
        r.status = bmhq_pkg::ST_MISSING;
        for (int unsigned i = 0; i < heap_size; i++) begin
          if (heap_ids[i] == cmd.node_id) begin
            heap_keys[i] = cmd.key;
            bubble_up(i);
            bubble_down(i);
            r.status = bmhq_pkg::ST_OK;
            break;
          end
        end
      end
      default: heap_size = 0;
    endcase
    r.count = heap_size[bmhq_pkg::COUNT_BITS-1:0];
    return r;
  endfunction

  // Driver: a command is held until its transfer, gaps drawn from the current idle percentage.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!start || taken) begin
        if (pending_cmds.size() != 0 && $urandom_range(99, 0) >= sender_idle_pct) begin
          req_i <= pending_cmds.pop_front();
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // A transfer happens at the rising edge where start is high and busy low.
  always @(posedge clk_i) begin
    taken <= rst_ni && start && !busy;
    if (rst_ni && start && !busy) begin
      expected_res.insert(expected_res.size(), apply_cmd(req_i));
      mode_hits[req_i.mode]++;
      cmds_sent++;
    end
  end

  // Monitor and watchdog.
  always @(posedge clk_i) begin
    bmhq_pkg::res_t exp_r;
    if (rst_ni) begin
      if ((start && !busy) || done_o) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (done_o) begin
        results_seen++;
        if (expected_res.size() == 0) begin
          $error("unexpected result: status %0d key %0h id %0h count %0d",
                 res_o.status, res_o.out_key, res_o.out_id, res_o.count);
          error_count++;
        end else begin
          exp_r = expected_res.pop_front();
          status_hits[exp_r.status]++;
          if (res_o.status !== exp_r.status) begin
            $error("status: expected %0d, got %0d", exp_r.status, res_o.status);
            error_count++;
          end
          if (res_o.out_key !== exp_r.out_key) begin
            $error("out_key: expected %0h, got %0h", exp_r.out_key, res_o.out_key);
            error_count++;
          end
          if (res_o.out_id !== exp_r.out_id) begin
            $error("out_id: expected %0h, got %0h", exp_r.out_id, res_o.out_id);
            error_count++;
          end
          if (res_o.count !== exp_r.count) begin
            $error("count: expected %0d, got %0d", exp_r.count, res_o.count);
            error_count++;
          end
        end
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired with %0d results outstanding", expected_res.size());
        $display("[binary_min_heap_queue_top] ERROR");
        $finish;
      end
    end
  end

  function automatic bmhq_pkg::req_t make_cmd(bmhq_pkg::mode_e m, int unsigned k,
                                              int unsigned d);
    bmhq_pkg::req_t c;
    c.mode = m;
    c.key = k[bmhq_pkg::KEY_BITS-1:0];
    c.node_id = d[bmhq_pkg::ID_BITS-1:0];
    return c;
  endfunction

  task automatic drain();
    while (pending_cmds.size() != 0 || start || expected_res.size() != 0) @(posedge clk_i);
  endtask

  // Inserts at insert_bias percent, rest mostly pops and updates; ids half the time from a small set.
  task automatic random_phase(int unsigned n, int unsigned idle_pct, int unsigned insert_bias);
    int unsigned r;
    bmhq_pkg::mode_e m;
    sender_idle_pct = idle_pct;
    for (int unsigned i = 0; i < n; i++) begin
      r = $urandom_range(99, 0);
      if (r < insert_bias) m = bmhq_pkg::MODE_INSERT;
      else if (r < insert_bias + (96 - insert_bias) / 2) m = bmhq_pkg::MODE_POP;
      else if (r < 97) m = bmhq_pkg::MODE_UPDATE;
      else m = bmhq_pkg::MODE_CLEAR;
      add_cmd(make_cmd(m,
        ($urandom_range(3, 0) == 0) ? $urandom_range(15, 0) : $urandom(),
        ($urandom_range(1, 0) == 0) ? $urandom_range(63, 0) : $urandom()));
    end
    drain();
  endtask

  initial begin
    rst_ni = 1'b0;
    start = 1'b0;
    req_i = '0;
    heap_size = 0;
    sender_idle_pct = 0;
    error_count = 0;
    cmds_sent = 0;
    results_seen = 0;
    idle_cycles = 0;
    taken = 1'b0;
    for (int i = 0; i < 4; i++) begin
      mode_hits[i] = 0;
      status_hits[i] = 0;
    end
    repeat (8) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // Directed: empty-heap errors, extremes, ties, duplicate ids, update and clear.
    add_cmd(make_cmd(bmhq_pkg::MODE_POP, 0, 0));
    add_cmd(make_cmd(bmhq_pkg::MODE_UPDATE, 5, 7));
    add_cmd(make_cmd(bmhq_pkg::MODE_INSERT, 16'hFFFF, 16'hFFFF));
    add_cmd(make_cmd(bmhq_pkg::MODE_INSERT, 0, 0));
    add_cmd(make_cmd(bmhq_pkg::MODE_INSERT, 100, 3));
    add_cmd(make_cmd(bmhq_pkg::MODE_INSERT, 100, 4));
    add_cmd(make_cmd(bmhq_pkg::MODE_INSERT, 50, 3));
    add_cmd(make_cmd(bmhq_pkg::MODE_UPDATE, 16'hFFFF, 3));
    add_cmd(make_cmd(bmhq_pkg::MODE_UPDATE, 1, 16'hFFFF));
    add_cmd(make_cmd(bmhq_pkg::MODE_UPDATE, 9, 16'h1234));
    add_cmd(make_cmd(bmhq_pkg::MODE_POP, 0, 0));
    add_cmd(make_cmd(bmhq_pkg::MODE_POP, 0, 0));
    add_cmd(make_cmd(bmhq_pkg::MODE_CLEAR, 16'hFFFF, 16'hFFFF));
    add_cmd(make_cmd(bmhq_pkg::MODE_POP, 0, 0));
    add_cmd(make_cmd(bmhq_pkg::MODE_UPDATE, 0, 0));
    drain();

    // Fill to capacity then overflow, update the last id inserted, pop one, clear.
    for (int unsigned i = 0; i < SLOTS; i++)
      add_cmd(make_cmd(bmhq_pkg::MODE_INSERT, $urandom(), i));
    add_cmd(make_cmd(bmhq_pkg::MODE_INSERT, 1, 1));
    add_cmd(make_cmd(bmhq_pkg::MODE_UPDATE, 0, SLOTS - 1));
    add_cmd(make_cmd(bmhq_pkg::MODE_POP, 0, 0));
    add_cmd(make_cmd(bmhq_pkg::MODE_CLEAR, 0, 0));
    drain();

    random_phase(180, 0, 60);
    random_phase(120, 73, 45);
    random_phase(180, 20, 70);
    random_phase(100, 0, 30);
    random_phase(100, 73, 50);

    repeat (50) @(posedge clk_i);
    $display("%0d commands sent, %0d results checked; modes I/P/U/C %0d/%0d/%0d/%0d",
             cmds_sent, results_seen, mode_hits[0], mode_hits[1], mode_hits[2], mode_hits[3]);
    $display("statuses ok/full/empty/missing %0d/%0d/%0d/%0d",
             status_hits[0], status_hits[1], status_hits[2], status_hits[3]);
    if (error_count == 0 && expected_res.size() == 0) begin
      $display("[binary_min_heap_queue_top] OK");
    end else begin
      $display("[binary_min_heap_queue_top] ERROR");
    end
    $finish;
  end
endmodule
